### src/depthwise_conv3x3_fixed_unit_macros.svh
// Assertion macros shared by the convolution unit.
// Each macro takes a label, the clock, a property expression and a message
// string; DWC3_ASSERT also takes the active-low reset.
`ifndef DEPTHWISE_CONV3X3_FIXED_UNIT_MACROS_SVH
`define DEPTHWISE_CONV3X3_FIXED_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DWC3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DWC3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWC3_ASSERT(label, clk, rst_n, prop, msg)
`define DWC3_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### src/dwc3_pkg.sv
package dwc3_pkg;

    // Line buffer geometry.
    localparam int MAX_WIDTH = 256;
    localparam int LINE_AW   = $clog2(MAX_WIDTH);
    localparam int PW_W      = 9;
    localparam int PH_W      = 13;
    localparam int SHIFT_W   = 5;

    // Data path widths.
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int NTAPS   = 9;
    localparam int NPART   = 5;
    localparam int COEF_W  = 4;
    localparam int TDATA_IN_W = 24;

    // Line RAM word: upper line in the high half, lower line in the low half.
    localparam int RAM_W = 2 * DATA_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PLANE_WIDTH  = 8'd0;
    localparam t_cfg_idx CFG_PLANE_HEIGHT = 8'd1;
    localparam t_cfg_idx CFG_FRAC_SHIFT   = 8'd2;
    localparam t_cfg_idx CFG_RELU_ENABLE  = 8'd3;

    // Coefficient slots: weights are 0 to 8, the bias follows.
    localparam logic [COEF_W-1:0] COEF_BIAS = 4'd9;

    // Operation carried in tuser.
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Register reset values.
    localparam logic [PW_W-1:0]    PW_RESET    = 9'd32;
    localparam logic [PH_W-1:0]    PH_RESET    = 13'd32;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd8;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;

endpackage

### src/dwc3_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module dwc3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/depthwise_conv3x3_fixed_unit.sv
// 3x3 depthwise convolution, stride 1, no padding, one channel plane at a time.
// Input stream: tuser selects a coefficient load (0) or a pixel (1). Coefficient
// requests write weight 0..8 (row-major) or the bias (index 9) and give no
// result; pixels stream a padded plane in row-major order.
// Output stream: one result per pixel with row and column of at least 2; tlast
// marks the bottom-right result of the plane.
// Configuration: a separate write channel that is always ready; write it only
// while the block is idle.
// Throughput: one request per cycle while the skid slot is free. The two
// previous rows live in a single line RAM read at accept and written back from
// stage 0; the two accesses always fall on different columns, so the line RAM
// never limits the rate. Pipeline: line RAM read at accept, then multiply,
// shift and pair sums, and the final sum into the output register.
// Reset clears the counters, window, coefficients and registers to their
// defaults; the line RAM is not cleared and needs no clearing pass.
// Stall: a skid slot behind the output register absorbs one result; while it is
// full, s_axis_tready is low and the whole pipeline holds.
`include "depthwise_conv3x3_fixed_unit_macros.svh"

module depthwise_conv3x3_fixed_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: [3:0] coef_index, [19:4] sample, [23:20] zero.
    input  logic [dwc3_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    // tuser: [0] op.
    input  logic                                 s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: [15:0] value.
    output logic [dwc3_pkg::DATA_W-1:0]          m_axis_tdata,
    output logic                                 m_axis_tlast,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dwc3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dwc3_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import dwc3_pkg::*;

    // Configuration registers.
    logic [PW_W-1:0]    r_plane_width;
    logic [PH_W-1:0]    r_plane_height;
    logic [SHIFT_W-1:0] r_frac_shift;
    logic               r_relu_enable;

    // Coefficients, window and position counters.
    t_sample            r_weights [NTAPS];
    t_sample            r_bias;
    t_sample            r_window [6];
    logic [LINE_AW-1:0] r_col;
    logic [PH_W-1:0]    r_row;

    // Pipeline registers.
    logic               r_s0_valid;
    logic               r_s0_emit;
    logic               r_s0_last;
    t_sample            r_s0_pix;
    logic [LINE_AW-1:0] r_s0_col;
    logic               r_s1_valid;
    logic               r_s1_last;
    t_prod              r_s1_prod [NTAPS];
    t_sample            r_s1_bias;
    logic               r_s2_valid;
    logic               r_s2_last;
    t_prod              r_s2_part [NPART];

    // Output register and skid slot.
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic               r_out_last;
    logic               r_skid_valid;
    logic [DATA_W-1:0]  r_skid_value;
    logic               r_skid_last;

    // Combinational signals.
    logic               en;
    logic               pix_acc;
    logic               coef_acc;
    logic [COEF_W-1:0]  in_coef_idx;
    t_sample            in_sample;
    logic [PW_W-1:0]    w_eff;
    logic [PH_W-1:0]    h_eff;
    logic [LINE_AW-1:0] c_eff;
    logic [PH_W-1:0]    r_pre;
    logic [PH_W-1:0]    r_eff;
    logic [PW_W-1:0]    c_next;
    logic [PH_W-1:0]    r_next;
    logic               emit;
    logic               is_last;
    logic [RAM_W-1:0]   ram_rdata;
    logic               ram_we;
    logic               ram_re;
    t_sample            top;
    t_sample            mid;
    t_sample            taps [NTAPS];
    t_prod              shifted [NTAPS];
    t_prod              total;
    logic [DATA_W-1:0]  result;
    logic               out_take;

    // Handshakes: the pipeline moves whenever the skid slot is free.
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign in_coef_idx   = s_axis_tdata[COEF_W-1:0];
    assign in_sample     = s_axis_tdata[COEF_W +: DATA_W];
    assign pix_acc       = s_axis_tvalid && en && (s_axis_tuser == OP_PIXEL);
    assign coef_acc      = s_axis_tvalid && en && (s_axis_tuser == OP_COEF);

    // Effective plane size after clamping.
    always_comb begin
        if (r_plane_width < PW_W'(3)) begin
            w_eff = PW_W'(3);
        end else if (r_plane_width > PW_W'(MAX_WIDTH)) begin
            w_eff = PW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_plane_width;
        end
        if (r_plane_height < PH_W'(3)) begin
            h_eff = PH_W'(3);
        end else begin
            h_eff = r_plane_height;
        end
    end

    // Position of the incoming pixel and the counters after it.
    always_comb begin
        if ({1'b0, r_col} >= w_eff) begin
            c_eff = '0;
            r_pre = r_row + PH_W'(1);
        end else begin
            c_eff = r_col;
            r_pre = r_row;
        end
        r_eff   = (r_pre >= h_eff) ? '0 : r_pre;
        emit    = (r_eff >= PH_W'(2)) && (c_eff >= LINE_AW'(2));
        is_last = (r_eff == h_eff - PH_W'(1)) && ({1'b0, c_eff} == w_eff - PW_W'(1));
        c_next  = {1'b0, c_eff} + PW_W'(1);
        r_next  = r_eff + PH_W'(1);
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_width  <= PW_RESET;
            r_plane_height <= PH_RESET;
            r_frac_shift   <= SHIFT_RESET;
            r_relu_enable  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLANE_WIDTH:  r_plane_width  <= i_cfg_data[PW_W-1:0];
                CFG_PLANE_HEIGHT: r_plane_height <= i_cfg_data[PH_W-1:0];
                CFG_FRAC_SHIFT:   r_frac_shift   <= i_cfg_data[SHIFT_W-1:0];
                CFG_RELU_ENABLE:  r_relu_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Coefficient loads; unused slots are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NTAPS; i++) begin
                r_weights[i] <= '0;
            end
            r_bias <= '0;
        end else if (coef_acc) begin
            if (in_coef_idx < COEF_BIAS) begin
                r_weights[in_coef_idx] <= in_sample;
            end else if (in_coef_idx == COEF_BIAS) begin
                r_bias <= in_sample;
            end
        end
    end

    // Column and row counters advance on each accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (c_next >= w_eff) begin
                r_col <= '0;
                r_row <= (r_next >= h_eff) ? '0 : r_next;
            end else begin
                r_col <= c_next[LINE_AW-1:0];
                r_row <= r_eff;
            end
        end
    end

    // Line RAM: upper line in the high half, lower line in the low half.
    // Reads happen at accept; the write-back of the same pixel follows from
    // stage 0, and the next pixel always sits on another column.
    assign ram_re = pix_acc;
    assign ram_we = r_s0_valid && en;

    dwc3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s0_col),
        .i_wdata ({mid, r_s0_pix}),
        .i_re    (ram_re),
        .i_raddr (c_eff),
        .o_rdata (ram_rdata)
    );

    // Stage 0 holds the pixel while its line data is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s0_pix  <= in_sample;
            r_s0_col  <= c_eff;
            r_s0_emit <= emit;
            r_s0_last <= is_last;
        end
    end

    // Window taps in weight order.
    assign top = ram_rdata[RAM_W-1:DATA_W];
    assign mid = ram_rdata[DATA_W-1:0];

    always_comb begin
        taps[0] = r_window[3];
        taps[1] = r_window[0];
        taps[2] = top;
        taps[3] = r_window[4];
        taps[4] = r_window[1];
        taps[5] = mid;
        taps[6] = r_window[5];
        taps[7] = r_window[2];
        taps[8] = r_s0_pix;
    end

    // The window shifts by one column for every pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_window[i] <= '0;
            end
        end else if (ram_we) begin
            r_window[3] <= r_window[0];
            r_window[4] <= r_window[1];
            r_window[5] <= r_window[2];
            r_window[0] <= top;
            r_window[1] <= mid;
            r_window[2] <= r_s0_pix;
        end
    end

    // Stage 1: nine products, one multiplier per tap; the bias travels along.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid && r_s0_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NTAPS; i++) begin
                r_s1_prod[i] <= taps[i] * r_weights[i];
            end
            r_s1_bias <= r_bias;
            r_s1_last <= r_s0_last;
        end
    end

    // Stage 2: arithmetic shift of each product, then pair sums.
    always_comb begin
        for (int i = 0; i < NTAPS; i++) begin
            shifted[i] = r_s1_prod[i] >>> r_frac_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_part[0] <= shifted[0] + shifted[1];
            r_s2_part[1] <= shifted[2] + shifted[3];
            r_s2_part[2] <= shifted[4] + shifted[5];
            r_s2_part[3] <= shifted[6] + shifted[7];
            r_s2_part[4] <= shifted[8] + PROD_W'(r_s1_bias);
            r_s2_last    <= r_s1_last;
        end
    end

    // Final wraparound sum and the optional clamp of negative sums.
    always_comb begin
        total = r_s2_part[0] + r_s2_part[1] + r_s2_part[2] + r_s2_part[3]
              + r_s2_part[4];
        if (r_relu_enable && total[PROD_W-1]) begin
            result = '0;
        end else begin
            result = total[DATA_W-1:0];
        end
    end

    // Output register with a one-entry skid slot behind it.
    assign out_take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_s2_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_value <= r_skid_value;
                r_out_last  <= r_skid_last;
            end
        end else if (r_s2_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_value <= result;
                r_skid_last  <= r_s2_last;
            end else begin
                r_out_value <= result;
                r_out_last  <= r_s2_last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tlast  = r_out_last;

    // The skid slot only fills behind a waiting result.
    `DWC3_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid,
        "skid full while output empty")

    // A line write-back never lands on the column being read in the same cycle.
    `DWC3_ASSERT(a_line_no_collision, i_clk, i_rst_n,
        (ram_we && ram_re) |-> (r_s0_col != c_eff),
        "line RAM read and write on the same column")

    // A pixel that yields a result reaches the multiply stage when the pipe moves.
    `DWC3_ASSERT(a_emit_advances, i_clk, i_rst_n,
        (r_s0_valid && r_s0_emit && en) |=> r_s1_valid,
        "result lost between stage 0 and stage 1")

    // A full skid slot empties exactly when the waiting result is taken.
    `DWC3_ASSERT(a_skid_drains, i_clk, i_rst_n,
        (r_skid_valid && m_axis_tready) |=> (!r_skid_valid && r_out_valid),
        "skid slot did not drain into the output register")

endmodule
